>>> src/sed_pkg.sv
package sed_pkg;

   localparam int DATA_WIDTH_DEF = 32;
   localparam int FRAC_BITS      = 16;
   localparam int OUT_W          = 64;
   localparam int MUL_STAGES     = 5;
   localparam int DIV_STEPS      = OUT_W;
   localparam int DIV_LAT        = DIV_STEPS + 2;

   localparam logic [OUT_W-1:0] SAT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
   localparam logic [OUT_W-1:0] SAT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

   typedef enum logic {
      CSR_STIFFNESS   = 1'b0,
      CSR_REST_LENGTH = 1'b1
   } csr_index_type;

endpackage

>>> src/spring_energy_derivatives.sv
// A request passes through the lane products, the merge, the square root, four
// multiply levels of five stages each, the 66-stage dividers and the output
// register before it appears as a response.
// Throughput: one transaction per cycle; the whole pipeline stalls only while
// the output register holds a response that is not taken.
// Reset clears the valid bits, the output register valid and both registers.
module spring_energy_derivatives #(
   parameter int DATA_WIDTH = sed_pkg::DATA_WIDTH_DEF
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_tvalid,
   output logic                                      req_tready,
   // offset_x/y/z, rate_i_x/y/z, rate_j_x/y/z, curv_x/y/z, DATA_WIDTH bits each
   input  logic [((12*DATA_WIDTH+7)/8)*8-1:0]        req_tdata,
   output logic                                      rsp_tvalid,
   input  logic                                      rsp_tready,
   // energy, grad_i, hess_ij, 64 bits each
   output logic [3*sed_pkg::OUT_W-1:0]               rsp_tdata,
   // zero_length
   output logic                                      rsp_tuser,
   input  logic                                      csr_valid,
   output logic                                      csr_ready,
   input  sed_pkg::csr_index_type                    csr_index,
   input  logic [DATA_WIDTH-1:0]                     csr_wdata
);

   localparam int DW   = DATA_WIDTH;
   localparam int F    = sed_pkg::FRAC_BITS;
   localparam int M    = sed_pkg::MUL_STAGES;
   localparam int OW   = sed_pkg::OUT_W;
   localparam int PRW  = 2 * DW;
   localparam int PW   = 2 * DW + 2;
   localparam int SW   = 2 * DW;
   localparam int TW   = SW + 2 * F;
   localparam int XW   = TW / 2;
   localparam int X1W  = XW + 1;
   localparam int DLW  = XW + 2;
   localparam int KDW  = DW + DLW;
   localparam int PPW  = 2 * PW;
   localparam int CXW  = PW + X1W;
   localparam int X2W  = 2 * X1W;
   localparam int ENW  = KDW + DLW;
   localparam int GNW  = KDW + PW;
   localparam int PXW  = PPW + X1W;
   localparam int CXXW = CXW + X1W;
   localparam int X3W  = X2W + X1W;
   localparam int AW   = PXW + 2 * F;
   localparam int B0W  = ((CXXW > PPW + 2 * F) ? CXXW : PPW + 2 * F) + 1;
   localparam int BDW  = B0W + DLW;
   localparam int HSW  = ((AW > BDW) ? AW : BDW) + 1;
   localparam int HNW  = HSW + DW;
   localparam int ESH  = 3 * F + 1;
   localparam int EXW  = (ENW > ESH + OW + 1) ? ENW : ESH + OW + 1;
   localparam int C1W  = DLW + PW + XW + 1;
   localparam int C2W  = PPW + DLW + XW + 1;
   localparam int C3W  = OW + GNW + PXW + X3W + XW + 1;
   localparam int C4W  = OW + GNW + X3W + XW + 1;
   localparam int PIPE = 2 + XW + 4 * M + sed_pkg::DIV_LAT;

   // ---------------- configuration ----------------
   logic signed [DW-1:0] stiff_ff, rest_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         stiff_ff <= '0;
         rest_ff  <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            sed_pkg::CSR_STIFFNESS:   stiff_ff <= csr_wdata;
            sed_pkg::CSR_REST_LENGTH: rest_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------- flow control ----------------
   logic            adv;
   logic [PIPE-1:0] valid_ff;
   logic            rsp_valid_ff;

   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff     <= {valid_ff[PIPE-2:0], req_tvalid};
         rsp_valid_ff <= valid_ff[PIPE-1];
      end
   end

   // ---------------- lanes: one per axis ----------------
   logic signed [PRW-1:0] vv [3];
   logic signed [PRW-1:0] vi [3];
   logic signed [PRW-1:0] vj [3];
   logic signed [PRW-1:0] ij [3];
   logic signed [PRW-1:0] vd [3];

   for (genvar c = 0; c < 3; c++) begin : g_lane
      sed_lane #(.DW(DW)) u_lane (
         .clock (clock),
         .en    (adv),
         .v     (req_tdata[c*DW +: DW]),
         .di    (req_tdata[(3+c)*DW +: DW]),
         .dj    (req_tdata[(6+c)*DW +: DW]),
         .dd    (req_tdata[(9+c)*DW +: DW]),
         .vv    (vv[c]),
         .vi    (vi[c]),
         .vj    (vj[c]),
         .ij    (ij[c]),
         .vd    (vd[c])
      );
   end

   // ---------------- merge ----------------
   logic signed [PW-1:0] sum_s;
   logic [SW-1:0]        s_ff;
   logic signed [PW-1:0] ii_ff, ij_ff, cc_ff;

   assign sum_s = PW'(vv[0]) + PW'(vv[1]) + PW'(vv[2]);

   always_ff @(posedge clock) begin
      if (adv) begin
         s_ff  <= sum_s[SW-1:0];
         ii_ff <= PW'(vi[0]) + PW'(vi[1]) + PW'(vi[2]);
         ij_ff <= PW'(vj[0]) + PW'(vj[1]) + PW'(vj[2]);
         cc_ff <= PW'(ij[0]) + PW'(ij[1]) + PW'(ij[2])
                + PW'(vd[0]) + PW'(vd[1]) + PW'(vd[2]);
      end
   end

   // ---------------- length ----------------
   logic [XW-1:0]   xr1;
   logic [3*PW-1:0] sq_side;

   sed_sqrt #(.TW(TW), .SBW(3*PW)) u_sqrt (
      .clock  (clock),
      .en     (adv),
      .val    ({s_ff, {(2*F){1'b0}}}),
      .side_i ({ii_ff, ij_ff, cc_ff}),
      .root   (xr1),
      .side_o (sq_side)
   );

   // ---------------- level 1 ----------------
   logic signed [PW-1:0]     ii1, ij1, cc1;
   logic signed [X1W-1:0]    x1;
   logic signed [DW+F-1:0]   x0s;
   logic signed [DLW-1:0]    dl0;
   logic                     zf0;
   logic signed [KDW-1:0]    kdl;
   logic signed [PPW-1:0]    pp;
   logic signed [CXW-1:0]    cx;
   logic signed [X2W-1:0]    x2;
   logic [C1W-1:0]           car1;

   assign {ii1, ij1, cc1} = sq_side;
   assign x1  = $signed({1'b0, xr1});
   assign x0s = $signed({rest_ff, {F{1'b0}}});
   assign dl0 = DLW'(x1) - DLW'(x0s);
   assign zf0 = xr1 == '0;

   sed_mul #(.WA(DLW), .WB(DW), .SBW(C1W)) u_kdl (
      .clock(clock), .en(adv), .a(dl0), .b(stiff_ff),
      .side_i({dl0, ii1, xr1, zf0}), .p(kdl), .side_o(car1));
   sed_mul #(.WA(PW), .WB(PW), .SBW(1)) u_pp (
      .clock(clock), .en(adv), .a(ii1), .b(ij1),
      .side_i(1'b0), .p(pp), .side_o());
   sed_mul #(.WA(PW), .WB(X1W), .SBW(1)) u_cx (
      .clock(clock), .en(adv), .a(cc1), .b(x1),
      .side_i(1'b0), .p(cx), .side_o());
   sed_mul #(.WA(X1W), .WB(X1W), .SBW(1)) u_x2 (
      .clock(clock), .en(adv), .a(x1), .b(x1),
      .side_i(1'b0), .p(x2), .side_o());

   // ---------------- level 2 ----------------
   logic signed [DLW-1:0]  dl2;
   logic signed [PW-1:0]   ii2;
   logic [XW-1:0]          xr2;
   logic                   zf2;
   logic signed [X1W-1:0]  x1b;
   logic signed [ENW-1:0]  en_p;
   logic signed [GNW-1:0]  gn;
   logic signed [PXW-1:0]  px;
   logic signed [CXXW-1:0] cxx;
   logic signed [X3W-1:0]  x3;
   logic [C2W-1:0]         car2;

   assign {dl2, ii2, xr2, zf2} = car1;
   assign x1b = $signed({1'b0, xr2});

   sed_mul #(.WA(KDW), .WB(DLW), .SBW(C2W)) u_en (
      .clock(clock), .en(adv), .a(kdl), .b(dl2),
      .side_i({pp, dl2, xr2, zf2}), .p(en_p), .side_o(car2));
   sed_mul #(.WA(KDW), .WB(PW), .SBW(1)) u_gn (
      .clock(clock), .en(adv), .a(kdl), .b(ii2),
      .side_i(1'b0), .p(gn), .side_o());
   sed_mul #(.WA(PPW), .WB(X1W), .SBW(1)) u_px (
      .clock(clock), .en(adv), .a(pp), .b(x1b),
      .side_i(1'b0), .p(px), .side_o());
   sed_mul #(.WA(CXW), .WB(X1W), .SBW(1)) u_cxx (
      .clock(clock), .en(adv), .a(cx), .b(x1b),
      .side_i(1'b0), .p(cxx), .side_o());
   sed_mul #(.WA(X2W), .WB(X1W), .SBW(1)) u_x3 (
      .clock(clock), .en(adv), .a(x2), .b(x1b),
      .side_i(1'b0), .p(x3), .side_o());

   // ---------------- level 3 ----------------
   logic signed [PPW-1:0] p3;
   logic signed [DLW-1:0] dl3;
   logic [XW-1:0]         xr3;
   logic                  zf3;
   logic signed [EXW-1:0] en_x;
   logic [EXW-ESH-OW:0]   en_hi;
   logic [OW-1:0]         esat;
   logic signed [B0W-1:0] b0;
   logic signed [BDW-1:0] bd;
   logic [C3W-1:0]        car3;

   assign {p3, dl3, xr3, zf3} = car2;

   // energy = floor(k dl^2 / 2^49), clamped
   assign en_x  = EXW'(en_p);
   assign en_hi = en_x[EXW-1:ESH+OW-1];
   assign esat  = ((&en_hi) || !(|en_hi)) ? en_x[ESH+OW-1:ESH]
                : (en_x[EXW-1] ? sed_pkg::SAT_MIN : sed_pkg::SAT_MAX);
   assign b0    = B0W'(cxx) - (B0W'(p3) <<< (2 * F));

   sed_mul #(.WA(B0W), .WB(DLW), .SBW(C3W)) u_bd (
      .clock(clock), .en(adv), .a(b0), .b(dl3),
      .side_i({esat, gn, px, x3, xr3, zf3}), .p(bd), .side_o(car3));

   // ---------------- level 4 ----------------
   logic [OW-1:0]         e4;
   logic signed [GNW-1:0] gn4;
   logic signed [PXW-1:0] px4;
   logic signed [X3W-1:0] x3_4;
   logic [XW-1:0]         xr4;
   logic                  zf4;
   logic signed [HSW-1:0] hs;
   logic signed [HNW-1:0] hn;
   logic [C4W-1:0]        car4;

   assign {e4, gn4, px4, x3_4, xr4, zf4} = car3;
   assign hs = HSW'(bd) + (HSW'(px4) <<< (2 * F));

   sed_mul #(.WA(HSW), .WB(DW), .SBW(C4W)) u_hn (
      .clock(clock), .en(adv), .a(hs), .b(stiff_ff),
      .side_i({e4, gn4, x3_4, xr4, zf4}), .p(hn), .side_o(car4));

   // ---------------- division ----------------
   logic [OW-1:0]         e5;
   logic signed [GNW-1:0] gn5;
   logic signed [X3W-1:0] x3_5;
   logic [XW-1:0]         xr5;
   logic                  zf5;
   logic [OW-1:0]         qg, qh, e6;
   logic                  zf6;

   assign {e5, gn5, x3_5, xr5, zf5} = car4;

   sed_div #(.NW(GNW), .DENW(XW+F), .SBW(OW+1)) u_div_g (
      .clock  (clock),
      .en     (adv),
      .num    (gn5),
      .den    ({xr5, {F{1'b0}}}),
      .side_i ({e5, zf5}),
      .q      (qg),
      .side_o ({e6, zf6})
   );

   sed_div #(.NW(HNW), .DENW(X3W+F), .SBW(1)) u_div_h (
      .clock  (clock),
      .en     (adv),
      .num    (hn),
      .den    ({x3_5, {F{1'b0}}}),
      .side_i (1'b0),
      .q      (qh),
      .side_o ()
   );

   // ---------------- output register ----------------
   logic [3*OW-1:0] rsp_data_ff;
   logic            rsp_zero_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= {zf6 ? '0 : qh, zf6 ? '0 : qg, e6};
         rsp_zero_ff <= zf6;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_zero_ff;

`ifndef SYNTHESIS
   a_zero_len_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[3*OW-1:OW] == '0)
      else $error("zero length response carries nonzero derivatives");

   a_rsp_from_pipe: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(valid_ff[PIPE-1]))
      else $error("response appeared without a pipeline transaction");

   a_stiff_write: assert property (@(posedge clock) disable iff (reset)
      csr_valid && !reset && csr_index == sed_pkg::CSR_STIFFNESS
      |=> stiff_ff == $past(csr_wdata))
      else $error("stiffness write lost");

   a_rest_write: assert property (@(posedge clock) disable iff (reset)
      csr_valid && !reset && csr_index == sed_pkg::CSR_REST_LENGTH
      |=> rest_ff == $past(csr_wdata))
      else $error("rest length write lost");
`endif

endmodule

>>> src/sed_lane.sv
module sed_lane #(
   parameter int DW = sed_pkg::DATA_WIDTH_DEF
) (
   input  logic                 clock,
   input  logic                 en,
   input  logic signed [DW-1:0] v,
   input  logic signed [DW-1:0] di,
   input  logic signed [DW-1:0] dj,
   input  logic signed [DW-1:0] dd,
   output logic signed [2*DW-1:0] vv,
   output logic signed [2*DW-1:0] vi,
   output logic signed [2*DW-1:0] vj,
   output logic signed [2*DW-1:0] ij,
   output logic signed [2*DW-1:0] vd
);

   logic signed [2*DW-1:0] vv_ff, vi_ff, vj_ff, ij_ff, vd_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         vv_ff <= v * v;
         vi_ff <= v * di;
         vj_ff <= v * dj;
         ij_ff <= di * dj;
         vd_ff <= v * dd;
      end
   end

   assign vv = vv_ff;
   assign vi = vi_ff;
   assign vj = vj_ff;
   assign ij = ij_ff;
   assign vd = vd_ff;

endmodule

>>> src/sed_mul.sv
module sed_mul #(
   parameter int WA  = 32,
   parameter int WB  = 32,
   parameter int SBW = 1
) (
   input  logic                    clock,
   input  logic                    en,
   input  logic signed [WA-1:0]    a,
   input  logic signed [WB-1:0]    b,
   input  logic [SBW-1:0]          side_i,
   output logic signed [WA+WB-1:0] p,
   output logic [SBW-1:0]          side_o
);

   localparam int M   = sed_pkg::MUL_STAGES;
   localparam int DG  = (WB + M - 1) / M;
   localparam int BXW = DG * M;
   localparam int AW2 = WA + BXW;
   localparam int PRD = WA + DG + 1;

   logic signed [WA-1:0]  a_ff   [M];
   logic signed [BXW-1:0] b_ff   [M];
   logic signed [AW2-1:0] acc_ff [M];
   logic [SBW-1:0]        sd_ff  [M];

   // one digit of b per stage, low digits unsigned, top digit signed
   for (genvar s = 0; s < M; s++) begin : g_stage
      logic signed [WA-1:0]  a_cur;
      logic signed [BXW-1:0] b_cur;
      logic signed [AW2-1:0] acc_cur;
      logic [SBW-1:0]        sd_cur;
      logic                  dmsb;
      logic signed [DG:0]    dig;
      logic signed [PRD-1:0] prod;
      logic signed [AW2-1:0] acc_in;

      if (s == 0) begin : g_first
         assign a_cur   = a;
         assign b_cur   = BXW'(b);
         assign acc_cur = '0;
         assign sd_cur  = side_i;
      end else begin : g_next
         assign a_cur   = a_ff[s-1];
         assign b_cur   = b_ff[s-1];
         assign acc_cur = acc_ff[s-1];
         assign sd_cur  = sd_ff[s-1];
      end

      if (s == M - 1) begin : g_top
         assign dmsb = b_cur[BXW-1];
      end else begin : g_low
         assign dmsb = 1'b0;
      end

      assign dig    = $signed({dmsb, b_cur[DG*s +: DG]});
      assign prod   = a_cur * dig;
      assign acc_in = acc_cur + (AW2'(prod) <<< (DG * s));

      always_ff @(posedge clock) begin
         if (en) begin
            a_ff[s]   <= a_cur;
            b_ff[s]   <= b_cur;
            acc_ff[s] <= acc_in;
            sd_ff[s]  <= sd_cur;
         end
      end
   end

   assign p      = acc_ff[M-1][WA+WB-1:0];
   assign side_o = sd_ff[M-1];

endmodule

>>> src/sed_sqrt.sv
module sed_sqrt #(
   parameter int TW  = 128,
   parameter int SBW = 1
) (
   input  logic              clock,
   input  logic              en,
   input  logic [TW-1:0]     val,
   input  logic [SBW-1:0]    side_i,
   output logic [TW/2-1:0]   root,
   output logic [SBW-1:0]    side_o
);

   localparam int RW = TW / 2;

   logic [TW-1:0]   val_ff  [RW];
   logic [RW+1:0]   rem_ff  [RW];
   logic [RW-1:0]   root_ff [RW];
   logic [SBW-1:0]  sd_ff   [RW];

   // one result bit per stage, two radicand bits consumed
   for (genvar s = 0; s < RW; s++) begin : g_stage
      logic [TW-1:0]  val_cur;
      logic [RW+1:0]  rem_cur;
      logic [RW-1:0]  root_cur;
      logic [SBW-1:0] sd_cur;
      logic [RW+1:0]  rem_sh;
      logic [RW+1:0]  trial;
      logic           ge;

      if (s == 0) begin : g_first
         assign val_cur  = val;
         assign rem_cur  = '0;
         assign root_cur = '0;
         assign sd_cur   = side_i;
      end else begin : g_next
         assign val_cur  = val_ff[s-1];
         assign rem_cur  = rem_ff[s-1];
         assign root_cur = root_ff[s-1];
         assign sd_cur   = sd_ff[s-1];
      end

      assign rem_sh = {rem_cur[RW-1:0], val_cur[TW-1 -: 2]};
      assign trial  = {root_cur, 2'b01};
      assign ge     = rem_sh >= trial;

      always_ff @(posedge clock) begin
         if (en) begin
            val_ff[s]  <= val_cur << 2;
            rem_ff[s]  <= ge ? rem_sh - trial : rem_sh;
            root_ff[s] <= {root_cur[RW-2:0], ge};
            sd_ff[s]   <= sd_cur;
         end
      end
   end

   assign root   = root_ff[RW-1];
   assign side_o = sd_ff[RW-1];

endmodule

>>> src/sed_div.sv
module sed_div #(
   parameter int NW   = 128,
   parameter int DENW = 64,
   parameter int SBW  = 1
) (
   input  logic                          clock,
   input  logic                          en,
   input  logic signed [NW-1:0]          num,
   input  logic [DENW-1:0]               den,
   input  logic [SBW-1:0]                side_i,
   output logic [sed_pkg::OUT_W-1:0]     q,
   output logic [SBW-1:0]                side_o
);

   localparam int OW = sed_pkg::OUT_W;
   localparam int NS = sed_pkg::DIV_STEPS;
   localparam int RW = DENW + 1;
   localparam int MW = (NW > DENW + OW + 1) ? NW : DENW + OW + 1;

   logic [RW-1:0]   r_ff   [NS+1];
   logic [OW-1:0]   lo_ff  [NS+1];
   logic [OW-1:0]   q_ff   [NS+1];
   logic [DENW-1:0] den_ff [NS+1];
   logic            neg_ff [NS+1];
   logic            ovf_ff [NS+1];
   logic [SBW-1:0]  sd_ff  [NS+1];
   logic [OW-1:0]   res_ff;
   logic [SBW-1:0]  sd_out_ff;

   logic          neg0;
   logic [NW-1:0] mag0;
   logic [MW-1:0] m0;
   logic          ovf0;

   // magnitude, and quotient overflow when |num| >= den * 2^64
   assign neg0 = num[NW-1];
   assign mag0 = neg0 ? NW'(-num) : NW'(num);
   assign m0   = MW'(mag0);
   assign ovf0 = m0[MW-1:OW] >= (MW-OW)'(den);

   always_ff @(posedge clock) begin
      if (en) begin
         r_ff[0]   <= m0[OW +: RW];
         lo_ff[0]  <= m0[OW-1:0];
         q_ff[0]   <= '0;
         den_ff[0] <= den;
         neg_ff[0] <= neg0;
         ovf_ff[0] <= ovf0;
         sd_ff[0]  <= side_i;
      end
   end

   for (genvar k = 1; k <= NS; k++) begin : g_step
      logic [RW-1:0] r_sh;
      logic          ge;

      assign r_sh = {r_ff[k-1][RW-2:0], lo_ff[k-1][OW-1]};
      assign ge   = r_sh >= {1'b0, den_ff[k-1]};

      always_ff @(posedge clock) begin
         if (en) begin
            r_ff[k]   <= ge ? r_sh - {1'b0, den_ff[k-1]} : r_sh;
            lo_ff[k]  <= lo_ff[k-1] << 1;
            q_ff[k]   <= {q_ff[k-1][OW-2:0], ge};
            den_ff[k] <= den_ff[k-1];
            neg_ff[k] <= neg_ff[k-1];
            ovf_ff[k] <= ovf_ff[k-1];
            sd_ff[k]  <= sd_ff[k-1];
         end
      end
   end

   logic          rnz;
   logic [OW:0]   qn;
   logic [OW:0]   qneg;
   logic [OW-1:0] res_in;

   // floor for negative numerators: -(q + 1) when a remainder is left
   assign rnz  = r_ff[NS] != '0;
   assign qn   = {1'b0, q_ff[NS]} + (OW+1)'(rnz);
   assign qneg = -qn;

   always_comb begin
      if (ovf_ff[NS]) begin
         res_in = neg_ff[NS] ? sed_pkg::SAT_MIN : sed_pkg::SAT_MAX;
      end else if (!neg_ff[NS]) begin
         res_in = q_ff[NS][OW-1] ? sed_pkg::SAT_MAX : q_ff[NS];
      end else if (qn > {2'b01, {(OW-1){1'b0}}}) begin
         res_in = sed_pkg::SAT_MIN;
      end else begin
         res_in = qneg[OW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff    <= res_in;
         sd_out_ff <= sd_ff[NS];
      end
   end

   assign q      = res_ff;
   assign side_o = sd_out_ff;

endmodule
